FILE: sv/pom_pkg.sv
// Shared types, constants and control words of the phase offset PSNR meter.
package pom_pkg;

    localparam int PIXEL_BITS = 24;
    localparam int FRAC_BITS  = 16;
    localparam int MAX_DIM    = 4096;

    localparam int DIM_W      = 13;
    localparam int CNT_W      = 12;
    localparam int DEPTH_W    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam int DIFF_W = PIXEL_BITS + 1;
    localparam int SQ_W   = 2 * PIXEL_BITS + 1;
    localparam int BSUM_W = 48;
    localparam int FSUM_W = 49;
    localparam int SSUM_W = 64;
    localparam int N_W    = 2 * DIM_W - 1;
    localparam int DEN_W  = 44;
    localparam int K_W    = 29;
    localparam int LOG_W  = 22;
    localparam int LV_W   = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIDE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_DEPTH    = 3'd3;

    localparam logic [DIM_W-1:0]   RST_WIDTH  = 13'd256;
    localparam logic [DIM_W-1:0]   RST_HEIGHT = 13'd256;
    localparam logic [DIM_W-1:0]   RST_SIDE   = 13'd100;
    localparam logic [DEPTH_W-1:0] RST_DEPTH  = 6'd8;
    localparam logic [DEPTH_W-1:0] MAX_DEPTH  = 6'd32;

    // 2*pi in Q30, rescaled to the pixel format with rounding
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
    localparam logic [63:0] TWO_PI =
        (TWO_PI_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    localparam logic [63:0] MSE_MIN     = 64'd16191 << (2 * FRAC_BITS - 32);
    localparam logic [63:0] TEN_LOG10_2 = 64'd197283;
    localparam logic signed [63:0] PSNR_ROUND = 64'sd1 <<< 23;
    localparam logic signed [63:0] PSNR_HI = 64'sd32767;
    localparam logic signed [63:0] PSNR_LO = -64'sd32768;
    localparam logic [15:0] PSNR_MAX = 16'h7FFF;
    localparam logic signed [LV_W-1:0] LV_BIAS = 25'(2 * FRAC_BITS * 65536);

    typedef struct packed {
        logic signed [PIXEL_BITS-1:0] ref_pixel;
        logic signed [PIXEL_BITS-1:0] test_pixel;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] psnr_db;
        logic               is_max;
        logic [31:0]        mse_value;
    } t_out_word;

    typedef enum logic [3:0] {
        OP_N   = 4'd0,
        OP_NB  = 4'd1,
        OP_DEN = 4'd2,
        OP_K   = 4'd3,
        OP_OFF = 4'd4,
        OP_Q   = 4'd5,
        OP_T1  = 4'd6,
        OP_T2  = 4'd7,
        OP_T3  = 4'd8,
        OP_OO  = 4'd9,
        OP_MSE = 4'd10,
        OP_LGP = 4'd11,
        OP_LGM = 4'd12,
        OP_PS  = 4'd13
    } t_op;

    typedef struct packed {
        logic accept;
        logic start;
        logic commit;
        logic load;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic done;
    } t_stat;

endpackage

FILE: sv/pom_div.sv
// Unsigned 64-bit restoring divider, one quotient bit per cycle.
module pom_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo,
    output logic [63:0] o_rem
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_quo;
    logic [63:0] r_rem;
    logic [63:0] r_den;
    logic [64:0] w_sh;
    logic        w_ge;
    logic [64:0] w_diff;

    assign w_sh   = {r_rem, r_quo[63]};
    assign w_ge   = w_sh >= {1'b0, r_den};
    assign w_diff = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[62:0], w_ge};
            r_rem <= w_ge ? w_diff[63:0] : w_sh[63:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

FILE: sv/pom_log.sv
// Base-2 logarithm in Q.16: leading-one search then sixteen squarings.
module pom_log (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [63:0]               i_x,
    output logic                      o_done,
    output logic [pom_pkg::LOG_W-1:0] o_res
);

    localparam logic [4:0] LOAD_STEP = 5'd6;
    localparam logic [4:0] LAST_STEP = 5'd22;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_x;
    logic [5:0]  r_n;
    logic [31:0] r_m;
    logic [15:0] r_frac;
    logic [63:0] w_sq;
    logic [32:0] w_s;

    assign w_sq = 64'(r_m) * 64'(r_m);
    assign w_s  = w_sq[63:31];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_n <= 6'd63;
        end else if (r_busy) begin
            // binary search for the leading one
            case (r_cnt)
                5'd0: if (r_x[63:32] == '0) begin r_x <= r_x << 32; r_n <= r_n - 6'd32; end
                5'd1: if (r_x[63:48] == '0) begin r_x <= r_x << 16; r_n <= r_n - 6'd16; end
                5'd2: if (r_x[63:56] == '0) begin r_x <= r_x << 8;  r_n <= r_n - 6'd8;  end
                5'd3: if (r_x[63:60] == '0) begin r_x <= r_x << 4;  r_n <= r_n - 6'd4;  end
                5'd4: if (r_x[63:62] == '0) begin r_x <= r_x << 2;  r_n <= r_n - 6'd2;  end
                5'd5: if (!r_x[63]) begin r_x <= r_x << 1; r_n <= r_n - 6'd1; end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            if (r_cnt == LOAD_STEP) begin
                r_m    <= r_x[63:32];
                r_frac <= '0;
            end else if (r_cnt > LOAD_STEP) begin
                if (w_s[32]) begin
                    r_m    <= w_s[32:1];
                    r_frac <= {r_frac[14:0], 1'b1};
                end else begin
                    r_m    <= w_s[31:0];
                    r_frac <= {r_frac[14:0], 1'b0};
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = {r_n, r_frac};

endmodule

FILE: sv/pom_dp.sv
// Datapath: settings, frame accumulators, shared multiply, divide and log units.
module pom_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pom_pkg::t_cmd                 i_cmd,
    output pom_pkg::t_stat                o_stat,
    input  logic                          i_cfg_we,
    input  logic [pom_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pom_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  pom_pkg::t_in_word             i_in,
    output pom_pkg::t_out_word            o_out
);

    // settings
    logic [pom_pkg::DIM_W-1:0]   r_width, r_height, r_side;
    logic [pom_pkg::DEPTH_W-1:0] r_depth;
    logic [pom_pkg::DIM_W-1:0]   w_bw, w_bh, w_dim;
    logic [pom_pkg::DEPTH_W-1:0] w_dep;

    assign w_dim = (i_cfg_data == '0) ? 13'd1 :
                   (i_cfg_data > 13'(pom_pkg::MAX_DIM)) ? 13'(pom_pkg::MAX_DIM) : i_cfg_data;
    assign w_dep = (i_cfg_data[5:0] == '0) ? 6'd1 :
                   (i_cfg_data[5:0] > pom_pkg::MAX_DEPTH) ? pom_pkg::MAX_DEPTH
                                                           : i_cfg_data[5:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= pom_pkg::RST_WIDTH;
            r_height <= pom_pkg::RST_HEIGHT;
            r_side   <= pom_pkg::RST_SIDE;
            r_depth  <= pom_pkg::RST_DEPTH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pom_pkg::CFG_IMAGE_WIDTH:  r_width  <= w_dim;
                pom_pkg::CFG_IMAGE_HEIGHT: r_height <= w_dim;
                pom_pkg::CFG_BLOCK_SIDE:   r_side   <= (i_cfg_data == '0) ? 13'd1 : i_cfg_data;
                pom_pkg::CFG_BIT_DEPTH:    r_depth  <= w_dep;
                default: ;
            endcase
        end
    end

    assign w_bw = (r_side < r_width)  ? r_side : r_width;
    assign w_bh = (r_side < r_height) ? r_side : r_height;

    // position counters
    logic [pom_pkg::CNT_W-1:0] r_col, r_row;
    logic w_row_last, w_col_last, w_last, w_inblk;

    assign w_row_last = ({1'b0, r_row} + 13'd1) >= r_height;
    assign w_col_last = ({1'b0, r_col} + 13'd1) >= r_width;
    assign w_last     = w_row_last & w_col_last;
    assign w_inblk    = ({1'b0, r_col} < w_bw) && ({1'b0, r_row} < w_bh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.accept) begin
            if (w_last) begin
                r_col <= '0;
                r_row <= '0;
            end else if (w_row_last) begin
                r_row <= '0;
                r_col <= r_col + 12'd1;
            end else begin
                r_row <= r_row + 12'd1;
            end
        end
    end

    // difference and square, registered ahead of the sums
    logic signed [pom_pkg::DIFF_W-1:0]   w_d, r_d;
    logic signed [2*pom_pkg::DIFF_W-1:0] w_sq_full;
    logic [pom_pkg::SQ_W-1:0]            r_sq;
    logic                                r_pv, r_inblk;

    assign w_d = {i_in.ref_pixel[pom_pkg::PIXEL_BITS-1], i_in.ref_pixel}
               - {i_in.test_pixel[pom_pkg::PIXEL_BITS-1], i_in.test_pixel};
    assign w_sq_full = w_d * w_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_d     <= w_d;
            r_sq    <= w_sq_full[pom_pkg::SQ_W-1:0];
            r_inblk <= w_inblk;
        end
    end

    // saturating sums
    logic signed [pom_pkg::BSUM_W-1:0] r_bsum;
    logic signed [pom_pkg::FSUM_W-1:0] r_fsum;
    logic [pom_pkg::SSUM_W-1:0]        r_ssum;
    logic signed [pom_pkg::BSUM_W:0]   w_bs;
    logic signed [pom_pkg::FSUM_W:0]   w_fs;
    logic [pom_pkg::SSUM_W:0]          w_ss;

    assign w_bs = {r_bsum[pom_pkg::BSUM_W-1], r_bsum} + (pom_pkg::BSUM_W+1)'(r_d);
    assign w_fs = {r_fsum[pom_pkg::FSUM_W-1], r_fsum} + (pom_pkg::FSUM_W+1)'(r_d);
    assign w_ss = {1'b0, r_ssum} + (pom_pkg::SSUM_W+1)'(r_sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            r_bsum <= '0;
            r_fsum <= '0;
            r_ssum <= '0;
        end else if (r_pv) begin
            if (r_inblk) begin
                if (w_bs[pom_pkg::BSUM_W] != w_bs[pom_pkg::BSUM_W-1])
                    r_bsum <= w_bs[pom_pkg::BSUM_W] ? {1'b1, {(pom_pkg::BSUM_W-1){1'b0}}}
                                                    : {1'b0, {(pom_pkg::BSUM_W-1){1'b1}}};
                else
                    r_bsum <= w_bs[pom_pkg::BSUM_W-1:0];
            end
            if (w_fs[pom_pkg::FSUM_W] != w_fs[pom_pkg::FSUM_W-1])
                r_fsum <= w_fs[pom_pkg::FSUM_W] ? {1'b1, {(pom_pkg::FSUM_W-1){1'b0}}}
                                                : {1'b0, {(pom_pkg::FSUM_W-1){1'b1}}};
            else
                r_fsum <= w_fs[pom_pkg::FSUM_W-1:0];
            r_ssum <= w_ss[pom_pkg::SSUM_W] ? '1 : w_ss[pom_pkg::SSUM_W-1:0];
        end
    end

    // frame-end scratch registers
    logic [pom_pkg::N_W-1:0]         r_n, r_nb;
    logic [pom_pkg::DEN_W-1:0]       r_den;
    logic [pom_pkg::K_W-1:0]         r_kmag;
    logic [63:0]                     r_off, r_q, r_r, r_t, r_p, r_c, r_mse;
    logic [pom_pkg::LOG_W-1:0]       r_lp;
    logic signed [pom_pkg::LV_W-1:0] r_lv;
    logic signed [15:0]              r_psnr;

    logic                        w_bneg, w_dneg, w_pneg;
    logic [pom_pkg::BSUM_W-1:0]  w_babs;
    logic [pom_pkg::FSUM_W-1:0]  w_dabs;
    logic [63:0]                 w_pabs;

    assign w_bneg = r_bsum[pom_pkg::BSUM_W-1];
    assign w_dneg = r_fsum[pom_pkg::FSUM_W-1];
    assign w_pneg = r_p[63];
    assign w_babs = w_bneg ? pom_pkg::BSUM_W'(-r_bsum) : pom_pkg::BSUM_W'(r_bsum);
    assign w_dabs = w_dneg ? pom_pkg::FSUM_W'(-r_fsum) : pom_pkg::FSUM_W'(r_fsum);
    assign w_pabs = w_pneg ? -r_p : r_p;

    // unit selection
    logic w_is_mul, w_is_div, w_is_log;
    logic [63:0] w_ma, w_mb, w_dnum, w_dden, w_lx;

    always_comb begin
        w_is_mul = i_cmd.op inside {pom_pkg::OP_N, pom_pkg::OP_NB, pom_pkg::OP_DEN,
                                    pom_pkg::OP_OFF, pom_pkg::OP_T1, pom_pkg::OP_T2,
                                    pom_pkg::OP_OO, pom_pkg::OP_PS};
        w_is_div = i_cmd.op inside {pom_pkg::OP_K, pom_pkg::OP_Q, pom_pkg::OP_T3,
                                    pom_pkg::OP_MSE};
        w_is_log = i_cmd.op inside {pom_pkg::OP_LGP, pom_pkg::OP_LGM};
        w_ma   = '0;
        w_mb   = '0;
        w_dnum = '0;
        w_dden = 64'd1;
        w_lx   = 64'((64'd1 << r_depth) - 64'd1);
        case (i_cmd.op)
            pom_pkg::OP_N:   begin w_ma = 64'(r_width); w_mb = 64'(r_height); end
            pom_pkg::OP_NB:  begin w_ma = 64'(w_bw);    w_mb = 64'(w_bh);     end
            pom_pkg::OP_DEN: begin w_ma = 64'(r_nb);    w_mb = pom_pkg::TWO_PI; end
            pom_pkg::OP_OFF: begin w_ma = 64'(r_kmag);  w_mb = pom_pkg::TWO_PI; end
            pom_pkg::OP_T1:  begin w_ma = r_off;        w_mb = r_q;           end
            pom_pkg::OP_T2:  begin w_ma = r_off;        w_mb = r_r;           end
            pom_pkg::OP_OO:  begin w_ma = r_off;        w_mb = r_off;         end
            pom_pkg::OP_PS:  begin w_ma = 64'(r_lv);    w_mb = pom_pkg::TEN_LOG10_2; end
            pom_pkg::OP_K: begin
                w_dnum = 64'({w_babs, 1'b0}) + 64'(r_den);
                w_dden = 64'({r_den, 1'b0});
            end
            pom_pkg::OP_Q:   begin w_dnum = 64'(w_dabs); w_dden = 64'(r_n); end
            pom_pkg::OP_T3:  begin w_dnum = w_pabs;      w_dden = 64'(r_n); end
            pom_pkg::OP_MSE: begin w_dnum = r_ssum;      w_dden = 64'(r_n); end
            pom_pkg::OP_LGM: w_lx = r_mse;
            default: ;
        endcase
    end

    // 64-bit wrapping multiply from three 32x32 partial products
    logic        r_mbusy, r_mdone;
    logic [1:0]  r_mcnt;
    logic [63:0] r_ma, r_mb, r_mprod, r_macc;
    logic [31:0] w_ma32, w_mb32;

    assign w_ma32 = (r_mcnt == 2'd2) ? r_ma[63:32] : r_ma[31:0];
    assign w_mb32 = (r_mcnt == 2'd1) ? r_mb[63:32] : r_mb[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mdone <= 1'b0;
            r_mcnt  <= '0;
        end else begin
            r_mdone <= 1'b0;
            if (i_cmd.start && w_is_mul) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= '0;
            end else if (r_mbusy) begin
                r_mcnt <= r_mcnt + 2'd1;
                if (r_mcnt == 2'd3) begin
                    r_mbusy <= 1'b0;
                    r_mdone <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start && w_is_mul) begin
            r_ma <= w_ma;
            r_mb <= w_mb;
        end else if (r_mbusy) begin
            r_mprod <= 64'(w_ma32) * 64'(w_mb32);
            case (r_mcnt)
                2'd1:    r_macc <= r_mprod;
                2'd2:    r_macc <= r_macc + {r_mprod[31:0], 32'd0};
                2'd3:    r_macc <= r_macc + {r_mprod[31:0], 32'd0};
                default: ;
            endcase
        end
    end

    logic        w_ddone, w_ldone;
    logic [63:0] w_dquo, w_drem;
    logic [pom_pkg::LOG_W-1:0] w_lres;

    pom_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start & w_is_div),
        .i_num   (w_dnum),
        .i_den   (w_dden),
        .o_done  (w_ddone),
        .o_quo   (w_dquo),
        .o_rem   (w_drem)
    );

    pom_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start & w_is_log),
        .i_x     (w_lx),
        .o_done  (w_ldone),
        .o_res   (w_lres)
    );

    assign o_stat.last = w_last;
    assign o_stat.done = r_mdone | w_ddone | w_ldone;

    // commit helpers
    logic [64:0]        w_madd;
    logic [63:0]        w_cmag;
    logic signed [63:0] w_pv, w_psh;

    assign w_madd = {1'b0, w_dquo} + {1'b0, r_c};
    assign w_cmag = -r_c;
    assign w_pv   = $signed(r_macc) + pom_pkg::PSNR_ROUND;
    assign w_psh  = w_pv >>> 24;

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            case (i_cmd.op)
                pom_pkg::OP_N:   r_n    <= r_macc[pom_pkg::N_W-1:0];
                pom_pkg::OP_NB:  r_nb   <= r_macc[pom_pkg::N_W-1:0];
                pom_pkg::OP_DEN: r_den  <= r_macc[pom_pkg::DEN_W-1:0];
                pom_pkg::OP_K:   r_kmag <= w_dquo[pom_pkg::K_W-1:0];
                pom_pkg::OP_OFF: r_off  <= w_bneg ? -r_macc : r_macc;
                pom_pkg::OP_Q: begin
                    r_q <= w_dneg ? -w_dquo : w_dquo;
                    r_r <= w_dneg ? -w_drem : w_drem;
                end
                pom_pkg::OP_T1:  r_t <= r_macc;
                pom_pkg::OP_T2:  r_p <= r_macc;
                pom_pkg::OP_T3:  r_t <= r_t + (w_pneg ? -w_dquo : w_dquo);
                pom_pkg::OP_OO:  r_c <= r_macc - {r_t[62:0], 1'b0};
                pom_pkg::OP_MSE: begin
                    if (!r_c[63])
                        r_mse <= w_madd[64] ? '1 : w_madd[63:0];
                    else
                        r_mse <= (w_dquo < w_cmag) ? '0 : w_dquo - w_cmag;
                end
                pom_pkg::OP_LGP: r_lp <= w_lres;
                pom_pkg::OP_LGM: r_lv <= $signed({2'b00, r_lp, 1'b0})
                                       - $signed({3'b000, w_lres}) + pom_pkg::LV_BIAS;
                pom_pkg::OP_PS: begin
                    if (w_psh > pom_pkg::PSNR_HI)      r_psnr <= 16'sh7FFF;
                    else if (w_psh < pom_pkg::PSNR_LO) r_psnr <= -16'sh8000;
                    else                               r_psnr <= w_psh[15:0];
                end
                default: ;
            endcase
        end
    end

    // result word
    logic [48:0] w_mq;
    logic        w_is_max;

    assign w_mq     = {1'b0, r_mse[63:16]} + 49'(r_mse[15]);
    assign w_is_max = r_mse <= pom_pkg::MSE_MIN;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_out.psnr_db   <= w_is_max ? pom_pkg::PSNR_MAX : r_psnr;
            o_out.is_max    <= w_is_max;
            o_out.mse_value <= (w_mq[48:32] != '0) ? 32'hFFFF_FFFF : w_mq[31:0];
        end
    end

endmodule

FILE: sv/pom_ctrl.sv
// Controller: handshakes, frame-end operation sequence and output valid.
module pom_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  pom_pkg::t_stat i_stat,
    output pom_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_ACC   = 4'b0001,
        S_ISSUE = 4'b0010,
        S_WAIT  = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state       r_state, n_state;
    pom_pkg::t_op r_op, n_op;
    logic         r_out_valid, n_out_valid;
    logic         w_accept;

    function automatic pom_pkg::t_op next_op(input pom_pkg::t_op op);
        case (op)
            pom_pkg::OP_N:   next_op = pom_pkg::OP_NB;
            pom_pkg::OP_NB:  next_op = pom_pkg::OP_DEN;
            pom_pkg::OP_DEN: next_op = pom_pkg::OP_K;
            pom_pkg::OP_K:   next_op = pom_pkg::OP_OFF;
            pom_pkg::OP_OFF: next_op = pom_pkg::OP_Q;
            pom_pkg::OP_Q:   next_op = pom_pkg::OP_T1;
            pom_pkg::OP_T1:  next_op = pom_pkg::OP_T2;
            pom_pkg::OP_T2:  next_op = pom_pkg::OP_T3;
            pom_pkg::OP_T3:  next_op = pom_pkg::OP_OO;
            pom_pkg::OP_OO:  next_op = pom_pkg::OP_MSE;
            pom_pkg::OP_MSE: next_op = pom_pkg::OP_LGP;
            pom_pkg::OP_LGP: next_op = pom_pkg::OP_LGM;
            pom_pkg::OP_LGM: next_op = pom_pkg::OP_PS;
            default:         next_op = pom_pkg::OP_N;
        endcase
    endfunction

    assign w_accept = i_in_valid && (r_state == S_ACC);

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_out_valid   = r_out_valid;
        o_cmd         = '0;
        o_cmd.op      = r_op;
        o_cmd.accept  = w_accept;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        case (r_state)
            S_ACC: begin
                if (w_accept && i_stat.last) begin
                    n_state = S_ISSUE;
                    n_op    = pom_pkg::OP_N;
                end
            end
            S_ISSUE: begin
                o_cmd.start = 1'b1;
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                if (i_stat.done) begin
                    o_cmd.commit = 1'b1;
                    if (r_op == pom_pkg::OP_PS) begin
                        n_state = S_OUT;
                    end else begin
                        n_op    = next_op(r_op);
                        n_state = S_ISSUE;
                    end
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_ACC;
                end
            end
            default: n_state = S_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_op        <= pom_pkg::OP_N;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_ACC);
    assign o_out_valid = r_out_valid;

endmodule

FILE: sv/phase_offset_psnr_meter.sv
// Phase offset PSNR meter: one pixel pair per cycle while a frame streams in
// (columns outer, rows top to bottom). The pair that closes the frame starts the
// frame-end computation, which runs on one shared 32x32 multiplier, a
// one-bit-per-cycle 64-bit divider and a squaring log2 unit; its run time is
// set mostly by the four divisions, and no pixel is taken meanwhile. The result
// word then sits in an output register while the next frame streams in; a
// second frame end waits for it to be taken. Settings must be written only while
// the block is idle; the block itself does not enforce this.
module phase_offset_psnr_meter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  pom_pkg::t_in_word             i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output pom_pkg::t_out_word            o_out,
    input  logic                          i_cfg_we,
    input  logic [pom_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pom_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    pom_pkg::t_cmd  w_cmd;
    pom_pkg::t_stat w_stat;

    pom_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    pom_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .o_out      (o_out)
    );

endmodule

FILE: tb/sv/phase_offset_psnr_meter_chk.sv
// Checker of the phase offset PSNR meter: predicts frame results and compares them.
`timescale 1ns / 1ps
module phase_offset_psnr_meter_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  pom_pkg::t_in_word             i_in,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  pom_pkg::t_out_word            i_out,
    input  logic                          i_cfg_we,
    input  logic [pom_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pom_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                            o_errors,
    output int                            o_pending
);

    localparam longint unsigned ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam longint unsigned TWOPI_Q = (64'd6746518852 + (64'd1 << 13)) >> 14;

    int unsigned width_r, height_r, side_r, depth_r;
    int unsigned col_pos, row_pos;
    longint      blk_sum, frm_sum;
    longint unsigned sq_sum;
    pom_pkg::t_out_word frame_results[$];

    function automatic longint clip_signed(longint v, int w);
        longint lim;
        lim = (longint'(1) <<< (w - 1)) - 1;
        if (v > lim) return lim;
        if (v < -lim - 1) return -lim - 1;
        return v;
    endfunction

    function automatic longint log2_q16(longint unsigned x);
        int n;
        longint unsigned m;
        longint frac;
        n = 0;
        frac = 0;
        while (n < 63 && (x >> n) > 1) n++;
        m = (n >= 31) ? (x >> (n - 31)) : (x << (31 - n));
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= (64'd1 << 32)) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return longint'(n) * 65536 + frac;
    endfunction

    // Accumulate one pixel pair; push a result when it closes the frame.
    task automatic accumulate_pixel(pom_pkg::t_in_word wd);
        int unsigned bw, bh;
        longint d, n, nb, den, k, off, q, r, t, corr, lp, lv, psnr;
        longint unsigned mag, sq, babs, mse, mq, peak;
        bit last;
        pom_pkg::t_out_word res;
        bw = side_r < width_r ? side_r : width_r;
        bh = side_r < height_r ? side_r : height_r;
        d = longint'(wd.ref_pixel) - longint'(wd.test_pixel);
        mag = d < 0 ? -d : d;
        sq = mag * mag;
        if (col_pos < bw && row_pos < bh) blk_sum = clip_signed(blk_sum + d, 48);
        frm_sum = clip_signed(frm_sum + d, 49);
        sq_sum = (ALL_ONES - sq_sum < sq) ? ALL_ONES : sq_sum + sq;
        last = (col_pos + 1 >= width_r) && (row_pos + 1 >= height_r);
        if (row_pos + 1 >= height_r) begin
            row_pos = 0;
            col_pos = (col_pos + 1) & 16'hFFFF;
        end else begin
            row_pos++;
        end
        if (!last) return;
        n = longint'(width_r) * longint'(height_r);
        nb = longint'(bw) * longint'(bh);
        den = nb * longint'(TWOPI_Q);
        babs = blk_sum < 0 ? -blk_sum : blk_sum;
        k = longint'((2 * babs + longint'(den)) / (2 * longint'(den)));
        if (blk_sum < 0) k = -k;
        off = k * longint'(TWOPI_Q);
        q = frm_sum / n;
        r = frm_sum - q * n;
        t = off * q + (off * r) / n;
        corr = off * off - 2 * t;
        mse = sq_sum / longint'(n);
        if (corr >= 0) mse = (ALL_ONES - mse < corr) ? ALL_ONES : mse + corr;
        else mse = (mse < longint'(-corr)) ? 0 : mse - longint'(-corr);
        mq = (mse >> 16) + ((mse >> 15) & 1);
        if (mq > 64'hFFFF_FFFF) mq = 64'hFFFF_FFFF;
        if (mse <= pom_pkg::MSE_MIN) begin
            res.psnr_db = pom_pkg::PSNR_MAX;
            res.is_max = 1'b1;
        end else begin
            peak = (64'd1 << depth_r) - 1;
            lp = peak > 0 ? log2_q16(peak) : 0;
            lv = 2 * lp - log2_q16(mse) + longint'(2 * pom_pkg::FRAC_BITS) * 65536;
            lv = lv * 197283 + (longint'(1) <<< 23);
            if (lv >= 0) psnr = longint'(longint'(lv) >> 24);
            else psnr = -longint'((longint'(-lv) + 64'hFF_FFFF) >> 24);
            if (psnr > 32767) psnr = 32767;
            if (psnr < -32768) psnr = -32768;
            res.psnr_db = psnr[15:0];
            res.is_max = 1'b0;
        end
        res.mse_value = mq[31:0];
        frame_results.push_back(res);
        col_pos = 0;
        row_pos = 0;
        blk_sum = 0;
        frm_sum = 0;
        sq_sum = 0;
    endtask

    always @(posedge i_clk) begin
        pom_pkg::t_out_word exp_w;
        if (!i_rst_n) begin
            width_r = 256;
            height_r = 256;
            side_r = 100;
            depth_r = 8;
            col_pos = 0;
            row_pos = 0;
            blk_sum = 0;
            frm_sum = 0;
            sq_sum = 0;
            frame_results.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pom_pkg::CFG_IMAGE_WIDTH: begin
                        width_r = i_cfg_data == 0 ? 1
                            : (i_cfg_data > pom_pkg::MAX_DIM ? pom_pkg::MAX_DIM
                            : i_cfg_data);
                    end
                    pom_pkg::CFG_IMAGE_HEIGHT: begin
                        height_r = i_cfg_data == 0 ? 1
                            : (i_cfg_data > pom_pkg::MAX_DIM ? pom_pkg::MAX_DIM
                            : i_cfg_data);
                    end
                    pom_pkg::CFG_BLOCK_SIDE: begin
                        side_r = i_cfg_data == 0 ? 1 : i_cfg_data;
                    end
                    pom_pkg::CFG_BIT_DEPTH: begin
                        depth_r = i_cfg_data[5:0] == 0 ? 1
                            : (i_cfg_data[5:0] > 32 ? 32 : i_cfg_data[5:0]);
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) accumulate_pixel(i_in);
            if (i_out_valid && i_out_ready) begin
                if (frame_results.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result word %p", i_out);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_w = frame_results.pop_front();
                    if (exp_w !== i_out) begin
                        if (o_errors < 10)
                            $display({"mismatch: expected psnr %0d max %0b mse %h,",
                                " got psnr %0d max %0b mse %h"},
                                exp_w.psnr_db, exp_w.is_max, exp_w.mse_value,
                                i_out.psnr_db, i_out.is_max, i_out.mse_value);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= frame_results.size();
    end
endmodule

FILE: tb/sv/phase_offset_psnr_meter_tb.sv
// Top of the phase offset PSNR meter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module phase_offset_psnr_meter_tb;

    localparam int SETTLE = 400;
    localparam int LIMIT = 3000000;
    localparam int TWOPI_Q = 411775;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    pom_pkg::t_in_word i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    pom_pkg::t_out_word o_out;
    logic i_cfg_we = 1'b0;
    logic [pom_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [pom_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    int errors, pending, cycles = 0;
    int send_idle = 0, recv_idle = 0;

    phase_offset_psnr_meter dut (.*);

    phase_offset_psnr_meter_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_in(i_in), .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle);
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("phase_offset_psnr_meter test failed");
            $finish;
        end
    end

    task automatic send_pair(logic signed [23:0] rp, logic signed [23:0] tp);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in.ref_pixel <= rp;
        i_in.test_pixel <= tp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Drain results and let the frame-end engine settle before a write.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [pom_pkg::CFG_IDX_W-1:0] idx, int val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[pom_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_frame(int w, int h, int side, int depth);
        wait_idle();
        write_reg(pom_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(pom_pkg::CFG_IMAGE_HEIGHT, h);
        write_reg(pom_pkg::CFG_BLOCK_SIDE, side);
        write_reg(pom_pkg::CFG_BIT_DEPTH, depth);
    endtask

    // Mostly near-equal pairs with a phase wrap, some full-range noise.
    task automatic send_random();
        int sel;
        logic signed [23:0] rp, tp;
        sel = $urandom_range(9);
        rp = 24'($urandom);
        if (sel < 5) tp = 24'(int'(rp) - int'($urandom_range(6)) * TWOPI_Q
            + int'($urandom_range(4000)) - 2000);
        else if (sel < 6) tp = rp;
        else if (sel < 7) tp = 24'(int'(rp) - TWOPI_Q * 3);
        else tp = 24'($urandom);
        send_pair(rp, tp);
    endtask

    initial begin
        int mode_send[3] = '{11, 65, 0};
        int mode_recv[3] = '{65, 11, 0};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // register clamps: zero and over-range values
        set_frame(0, 8191, 0, 63);
        set_frame(2, 2, 1, 8);
        // extremes and a zero-error frame
        send_pair(24'sh7FFFFF, 24'sh800000);
        send_pair(24'sh800000, 24'sh7FFFFF);
        send_pair(24'sh7FFFFF, 24'sh7FFFFF);
        send_pair(24'sh800000, 24'sh800000);
        repeat (4) send_pair(24'sh012345, 24'sh012345);
        send_pair(24'sh000000, -24'sd411775);
        repeat (3) send_pair(24'sh001000, 24'sh001000 + 24'sd411775);
        set_frame(1, 1, 4096, 32);
        send_pair(24'sh7FFFFF, 24'sh000000);
        send_pair(24'sh000010, 24'sh000000);
        set_frame(3, 2, 2, 1);
        repeat (6) send_pair(24'sh000000, 24'sh000200);
        set_frame(4, 3, 4096, 16);
        repeat (6) send_random();
        // write mid-frame: new size applies to the open frame
        set_frame(2, 2, 1, 8);
        repeat (5) send_random();
        for (int m = 0; m < 3; m++) begin
            send_idle = mode_send[m];
            recv_idle = mode_recv[m];
            for (int p = 0; p < 6; p++) begin
                set_frame($urandom_range(6, 1), $urandom_range(6, 1),
                    $urandom_range(8, 1), $urandom_range(63));
                repeat (21) begin
                    send_random();
                end
                if (m == 0 && p == 2) begin
                    i_in_valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
            end
        end
        set_frame(1, 40, 4096, 8);
        repeat (40) send_random();
        wait_idle();
        if (errors == 0) begin
            $display("phase_offset_psnr_meter test passed");
        end else begin
            $display("phase_offset_psnr_meter test failed");
        end
        $finish;
    end
endmodule

FILE: files.f
sv/pom_pkg.sv
sv/pom_div.sv
sv/pom_log.sv
sv/pom_dp.sv
sv/pom_ctrl.sv
sv/phase_offset_psnr_meter.sv
tb/sv/phase_offset_psnr_meter_chk.sv
tb/sv/phase_offset_psnr_meter_tb.sv
